/* rtl/aes_pkg.sv */
package aes_pkg;

  localparam int Rounds = 10;

  typedef enum logic [1:0] {
    CFG_KEY_HIGH  = 2'd0,
    CFG_KEY_LOW   = 2'd1,
    CFG_DIRECTION = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_high;
    logic [63:0] out_low;
  } out_item_t;

  // one block in flight through the round chain
  typedef struct packed {
    logic         vld;
    logic         dec;
    logic [127:0] st;
    logic [127:0] rk;
    logic [7:0]   rcon;
  } aes_lane_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] ISBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] b);
    xt = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the block, byte 0 in the top bits
  function automatic logic [7:0] byte_of(input logic [127:0] s, input int i);
    byte_of = s[127-8*i -: 8];
  endfunction

  // next round key (forward schedule)
  function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    t  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    key_fwd = {w0, w1, w2, w3};
  endfunction

  // previous round key (schedule run backwards)
  function automatic logic [127:0] key_bwd(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    w3 = k[31:0] ^ k[63:32];
    w2 = k[63:32] ^ k[95:64];
    w1 = k[95:64] ^ k[127:96];
    t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = k[127:96] ^ t;
    key_bwd = {w0, w1, w2, w3};
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    mix_col = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
               a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
               a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
               xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3, u, v;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    // premultiply by {04 ... 05} form, then forward mix
    u = xt(xt(a0 ^ a2));
    v = xt(xt(a1 ^ a3));
    inv_mix_col = mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
  endfunction

  localparam logic [7:0] RCON_LAST = 8'h36;

endpackage

/* rtl/aes_round_cell.sv */
module aes_round_cell
  import aes_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      last,
  input  aes_lane_t lane_i,
  output aes_lane_t lane_o
);

  aes_lane_t lane_r, lane_nxt;

  logic [127:0] sr, sub, mix, enc_st, dec_st, rk_f, rk_b, isr, isub, xk;

  always_comb begin
    // encrypt: SubBytes, ShiftRows, MixColumns, then next key
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sub[127-8*(4*c+r) -: 8] = SBOX[byte_of(lane_i.st, 4*((c+r)%4)+r)];
        isr[127-8*(4*((c+r)%4)+r) -: 8] = byte_of(lane_i.st, 4*c+r);
      end
    end
    sr = sub;
    for (int c = 0; c < 4; c++) begin
      mix[127-32*c -: 32] = mix_col(sr[127-32*c -: 32]);
    end
    rk_f   = key_fwd(lane_i.rk, lane_i.rcon);
    enc_st = (last ? sr : mix) ^ rk_f;
    // decrypt: InvShiftRows, InvSubBytes, AddRoundKey with previous key, InvMix
    for (int i = 0; i < 16; i++) begin
      isub[127-8*i -: 8] = ISBOX[byte_of(isr, i)];
    end
    rk_b = key_bwd(lane_i.rk, lane_i.rcon);
    xk   = isub ^ rk_b;
    for (int c = 0; c < 4; c++) begin
      dec_st[127-32*c -: 32] = last ? xk[127-32*c -: 32] : inv_mix_col(xk[127-32*c -: 32]);
    end
    lane_nxt.vld  = lane_i.vld;
    lane_nxt.dec  = lane_i.dec;
    lane_nxt.st   = lane_i.dec ? dec_st : enc_st;
    lane_nxt.rk   = lane_i.dec ? rk_b : rk_f;
    lane_nxt.rcon = lane_i.dec ? {1'b0, lane_i.rcon[7:1]} ^ (lane_i.rcon[0] ? 8'h8d : 8'h00)
                               : xt(lane_i.rcon);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.vld <= 1'b0;
    end else begin
      lane_r.vld <= lane_nxt.vld;
    end
    lane_r.dec  <= lane_nxt.dec;
    lane_r.st   <= lane_nxt.st;
    lane_r.rk   <= lane_nxt.rk;
    lane_r.rcon <= lane_nxt.rcon;
  end

  assign lane_o = lane_r;

endmodule

/* rtl/aes128_block_cipher_unit.sv */
// AES-128 (FIPS-197) encrypt/decrypt engine. A block is taken at every rising
// edge where start is high and busy is low, so blocks can follow back to back.
// Its result is on out_item with out_valid high for exactly one cycle, once it
// has passed the input register and every round register. The path is
// one input cell that does the initial key add, then a chain of ten round
// cells with one register each. After a write to either key register, busy
// stays high while the schedule is walked forward to find the last round key
// that decryption starts from. Writing the direction
// does not raise busy. The receiver cannot stall, so every result must be
// taken in its cycle. Key and direction are sampled as a block enters.
module aes128_block_cipher_unit
  import aes_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  in_item_t     in_item,
  output logic         out_valid,
  output out_item_t    out_item,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  logic [63:0] key_high_r, key_low_r;
  logic        direction_r;
  logic [127:0] dec_key_r;     // last round key, for decryption
  logic [127:0] kx_r, kx_nxt;  // key schedule walk after a key write
  logic [3:0]   kcnt_r;
  logic [7:0]   krc_r;
  logic         key_wr;

  aes_lane_t lane_in_r, lane_in_nxt;
  aes_lane_t chain [Rounds+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r  <= '0;
      key_low_r   <= '0;
      direction_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_KEY_HIGH:  key_high_r  <= cfg_data;
        CFG_KEY_LOW:   key_low_r   <= cfg_data;
        CFG_DIRECTION: direction_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign key_wr = cfg_we && (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW);

  // walk the schedule once after any key change to find the last round key
  assign kx_nxt = key_fwd(kx_r, krc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kcnt_r <= 4'(Rounds);
    end else if (key_wr) begin
      kcnt_r <= '0;
    end else if (kcnt_r != 4'(Rounds)) begin
      kcnt_r <= kcnt_r + 4'd1;
    end
    if (key_wr) begin
      kx_r  <= {cfg_index == CFG_KEY_HIGH ? cfg_data : key_high_r,
                cfg_index == CFG_KEY_LOW  ? cfg_data : key_low_r};
      krc_r <= 8'h01;
    end else if (kcnt_r != 4'(Rounds)) begin
      kx_r  <= kx_nxt;
      krc_r <= xt(krc_r);
    end
  end

  // reset key is zero; its last round key is a fixed value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_key_r <= 128'hb4ef5bcb3e92e21123e951cf6f8f188e;
    end else if (kcnt_r == 4'(Rounds - 1)) begin
      dec_key_r <= kx_nxt;
    end
  end

  // hold off blocks until the last round key is ready
  assign busy = (kcnt_r != 4'(Rounds));

  always_comb begin
    lane_in_nxt.vld  = start && !busy;
    lane_in_nxt.dec  = direction_r;
    lane_in_nxt.rk   = direction_r ? dec_key_r : {key_high_r, key_low_r};
    lane_in_nxt.st   = {in_item.block_high, in_item.block_low} ^ lane_in_nxt.rk;
    lane_in_nxt.rcon = direction_r ? RCON_LAST : 8'h01;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_in_r.vld <= 1'b0;
    end else begin
      lane_in_r.vld <= lane_in_nxt.vld;
    end
    lane_in_r.dec  <= lane_in_nxt.dec;
    lane_in_r.st   <= lane_in_nxt.st;
    lane_in_r.rk   <= lane_in_nxt.rk;
    lane_in_r.rcon <= lane_in_nxt.rcon;
  end

  assign chain[0] = lane_in_r;

  for (genvar g = 0; g < Rounds; g++) begin : g_round
    aes_round_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .last   (g == Rounds - 1),
      .lane_i (chain[g]),
      .lane_o (chain[g+1])
    );
  end

  assign out_valid = chain[Rounds].vld;
  assign out_item  = {chain[Rounds].st[127:64], chain[Rounds].st[63:0]};

  a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ##(Rounds + 1) (out_valid == $past(start && !busy, Rounds + 1)))
    else $error("result strobe does not follow transfer");
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !lane_in_r.vld)
    else $error("block taken while busy");
  a_chain_vld: assert property (@(posedge clk) disable iff (!rst_n)
    chain[1].vld |=> chain[2].vld)
    else $error("round chain lost a block");

endmodule
